>>> rtl/core/tfsb_pkg.sv
`timescale 1ns / 1ps

package tfsb_pkg;

  // Field widths
  localparam int CoordW  = 32;            // Q16.16 coordinates and results
  localparam int TrigW   = 16;            // Q1.14 cosine and sine
  localparam int DiffW   = CoordW + 1;    // exact difference of two coordinates
  localparam int ProdW   = DiffW + TrigW; // trig times difference
  localparam int SumW    = ProdW + 1;     // sum of two products
  localparam int FracSh  = 14;            // Q1.14 scaling
  localparam int RotW    = SumW - FracSh; // rotated value after rounding shift
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 32;

  // Round half up before dropping the Q1.14 fraction
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) <<< (FracSh - 1);

  // Reset value of the cosine register: 1.0 in Q1.14
  localparam logic signed [TrigW-1:0] CosOne = TrigW'(1) <<< FracSh;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [TrigW-1:0]  trig_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_X,
    CFG_TARGET_Y,
    CFG_ROT_COS,
    CFG_ROT_SIN
  } cfg_idx_e;

  // Current configuration as seen by the datapath
  typedef struct packed {
    coord_t target_x;
    coord_t target_y;
    trig_t  rot_cos;
    trig_t  rot_sin;
  } cfg_t;

  // Position beat handed from the rotation pipe to the kinematics stage
  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    logic   restart;
  } pos_beat_t;

  // Saturate the rounded rotation result to 32 bits
  function automatic coord_t sat_rot(input logic signed [RotW-1:0] v);
    coord_t r;
    if ((v[RotW-1:CoordW-1] == '0) || (v[RotW-1:CoordW-1] == '1)) begin
      r = v[CoordW-1:0];
    end else if (v[RotW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  // Exact difference a - b, saturated to 32 bits
  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    logic signed [DiffW-1:0] d;
    coord_t r;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (d[DiffW-1] == d[DiffW-2]) begin
      r = d[CoordW-1:0];
    end else if (d[DiffW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tfsb_point_if.sv
`timescale 1ns / 1ps

interface tfsb_point_if;
  logic             valid;
  logic             ready;
  tfsb_pkg::coord_t raw_x;
  tfsb_pkg::coord_t raw_y;
  logic             restart;

  modport source (output valid, output raw_x, output raw_y, output restart, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input restart, output ready);
endinterface

>>> rtl/core/tfsb_state_if.sv
`timescale 1ns / 1ps

interface tfsb_state_if;
  logic             valid;
  logic             ready;
  tfsb_pkg::coord_t pos_x;
  tfsb_pkg::coord_t pos_y;
  tfsb_pkg::coord_t vel_x;
  tfsb_pkg::coord_t vel_y;
  tfsb_pkg::coord_t acc_x;
  tfsb_pkg::coord_t acc_y;

  modport source (
    output valid, output pos_x, output pos_y, output vel_x, output vel_y,
    output acc_x, output acc_y, input ready
  );
  modport sink (
    input valid, input pos_x, input pos_y, input vel_x, input vel_y,
    input acc_x, input acc_y, output ready
  );
endinterface

>>> rtl/core/tfsb_cfg_if.sv
`timescale 1ns / 1ps

interface tfsb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tfsb_pkg::CfgIdxW-1:0]       index;
  logic [tfsb_pkg::CfgDatW-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/target_frame_state_builder.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake     | Payload
// cfg_i    | in        | valid / ready | index, data (register write)
// point_i  | in        | valid / ready | raw_x, raw_y, restart
// state_o  | out       | valid / ready | pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
//
// One point per cycle while state_o is not stalled; a taken point moves through the
// input, product, position and output regs before state_o.valid rises and it can leave.
// Reset clears all valid bits and history and loads target 0, cos 1.0, sin 0.
// A stall on state_o holds the output beat; upstream stages keep filling empty slots,
// so point_i.ready drops only once every stage holds a beat.
// cfg_i.ready is always high; config is sampled by the datapath as items flow.

module target_frame_state_builder import tfsb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tfsb_cfg_if.sink     cfg_i,
  tfsb_point_if.sink   point_i,
  tfsb_state_if.source state_o
);

  cfg_t      cfg;
  logic      pos_valid;
  logic      pos_ready;
  pos_beat_t pos_beat;

  tfsb_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tfsb_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .point_i     (point_i),
    .pos_valid_o (pos_valid),
    .pos_ready_i (pos_ready),
    .pos_o       (pos_beat)
  );

  tfsb_kinematics u_kinematics (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pos_valid_i (pos_valid),
    .pos_ready_o (pos_ready),
    .pos_i       (pos_beat),
    .state_o     (state_o)
  );

endmodule

>>> rtl/core/tfsb_cfg_regs.sv
`timescale 1ns / 1ps

module tfsb_cfg_regs import tfsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfsb_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_TARGET_X: cfg_d.target_x = cfg_i.data[CoordW-1:0];
        CFG_TARGET_Y: cfg_d.target_y = cfg_i.data[CoordW-1:0];
        CFG_ROT_COS:  cfg_d.rot_cos  = cfg_i.data[TrigW-1:0];
        CFG_ROT_SIN:  cfg_d.rot_sin  = cfg_i.data[TrigW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_x <= '0;
      cfg_q.target_y <= '0;
      cfg_q.rot_cos  <= CosOne;
      cfg_q.rot_sin  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/tfsb_rotate.sv
`timescale 1ns / 1ps

module tfsb_rotate import tfsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  tfsb_point_if.sink point_i,
  output logic       pos_valid_o,
  input  logic       pos_ready_i,
  output pos_beat_t  pos_o
);

  // Stage 0: captured input point
  logic   v0_q;
  coord_t raw_x_q, raw_y_q;
  logic   rst0_q;

  // Stage 1: registered products
  logic                    v1_q;
  logic signed [ProdW-1:0] p_cx_q, p_sy_q, p_sx_q, p_cy_q;
  logic                    rst1_q;

  // Stage 2: rounded, saturated position
  logic      v2_q;
  pos_beat_t pos_q;

  logic en0, en1, en2;

  // Bubble-collapsing stall chain
  assign en2 = !v2_q || pos_ready_i;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign point_i.ready = en0;

  // Offset from target and rotation products
  logic signed [DiffW-1:0] dx, dy;
  logic signed [ProdW-1:0] p_cx_d, p_sy_d, p_sx_d, p_cy_d;

  always_comb begin
    dx     = {raw_x_q[CoordW-1], raw_x_q} - {cfg_i.target_x[CoordW-1], cfg_i.target_x};
    dy     = {raw_y_q[CoordW-1], raw_y_q} - {cfg_i.target_y[CoordW-1], cfg_i.target_y};
    p_cx_d = ProdW'(cfg_i.rot_cos) * ProdW'(dx);
    p_sy_d = ProdW'(cfg_i.rot_sin) * ProdW'(dy);
    p_sx_d = ProdW'(cfg_i.rot_sin) * ProdW'(dx);
    p_cy_d = ProdW'(cfg_i.rot_cos) * ProdW'(dy);
  end

  // Sum, round half up, drop fraction, saturate
  logic signed [SumW-1:0] sum_x, sum_y;
  pos_beat_t              pos_d;

  always_comb begin
    sum_x = {p_cx_q[ProdW-1], p_cx_q} - {p_sy_q[ProdW-1], p_sy_q} + RoundHalf;
    sum_y = {p_sx_q[ProdW-1], p_sx_q} + {p_cy_q[ProdW-1], p_cy_q} + RoundHalf;
    pos_d.pos_x   = sat_rot(sum_x[SumW-1:FracSh]);
    pos_d.pos_y   = sat_rot(sum_y[SumW-1:FracSh]);
    pos_d.restart = rst1_q;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= point_i.valid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en0 && point_i.valid) begin
      raw_x_q <= point_i.raw_x;
      raw_y_q <= point_i.raw_y;
      rst0_q  <= point_i.restart;
    end
    if (en1 && v0_q) begin
      p_cx_q <= p_cx_d;
      p_sy_q <= p_sy_d;
      p_sx_q <= p_sx_d;
      p_cy_q <= p_cy_d;
      rst1_q <= rst0_q;
    end
    if (en2 && v1_q) begin
      pos_q <= pos_d;
    end
  end

  assign pos_valid_o = v2_q;
  assign pos_o       = pos_q;

endmodule

>>> rtl/core/tfsb_kinematics.sv
`timescale 1ns / 1ps

module tfsb_kinematics import tfsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pos_valid_i,
  output logic        pos_ready_o,
  input  pos_beat_t   pos_i,
  tfsb_state_if.source state_o
);

  // History of the last beat loaded into the output register
  coord_t prev_pos_x_q, prev_pos_y_q, prev_vel_x_q, prev_vel_y_q;
  logic   hist_q;

  // Output register
  logic   ov_q;
  coord_t pos_x_q, pos_y_q, vel_x_q, vel_y_q, acc_x_q, acc_y_q;

  logic   load;
  logic   use_hist;
  coord_t vel_x_d, vel_y_d, acc_x_d, acc_y_d;

  assign pos_ready_o = !ov_q || state_o.ready;
  assign load        = pos_valid_i && pos_ready_o;
  assign use_hist    = hist_q && !pos_i.restart;

  // Velocity and acceleration, zero without history or on a restart beat
  always_comb begin
    vel_x_d = '0;
    vel_y_d = '0;
    acc_x_d = '0;
    acc_y_d = '0;
    if (use_hist) begin
      vel_x_d = sat_sub(pos_i.pos_x, prev_pos_x_q);
      vel_y_d = sat_sub(pos_i.pos_y, prev_pos_y_q);
      acc_x_d = sat_sub(vel_x_d, prev_vel_x_q);
      acc_y_d = sat_sub(vel_y_d, prev_vel_y_q);
    end
  end

  // Control and history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q         <= 1'b0;
      hist_q       <= 1'b0;
      prev_pos_x_q <= '0;
      prev_pos_y_q <= '0;
      prev_vel_x_q <= '0;
      prev_vel_y_q <= '0;
    end else begin
      if (pos_ready_o) ov_q <= pos_valid_i;
      if (load) begin
        hist_q       <= 1'b1;
        prev_pos_x_q <= pos_i.pos_x;
        prev_pos_y_q <= pos_i.pos_y;
        prev_vel_x_q <= vel_x_d;
        prev_vel_y_q <= vel_y_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_x_q <= pos_i.pos_x;
      pos_y_q <= pos_i.pos_y;
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
    end
  end

  assign state_o.valid = ov_q;
  assign state_o.pos_x = pos_x_q;
  assign state_o.pos_y = pos_y_q;
  assign state_o.vel_x = vel_x_q;
  assign state_o.vel_y = vel_y_q;
  assign state_o.acc_x = acc_x_q;
  assign state_o.acc_y = acc_y_q;

`ifndef SYNTHESIS
  // A restart beat leaves with zero velocity and acceleration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && pos_i.restart |=> vel_x_q == '0 && vel_y_q == '0 && acc_x_q == '0 && acc_y_q == '0)
    else $error("restart beat carries nonzero velocity or acceleration");

  // Stored history tracks the beat just loaded into the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> hist_q && prev_pos_x_q == pos_x_q && prev_pos_y_q == pos_y_q
             && prev_vel_x_q == vel_x_q && prev_vel_y_q == vel_y_q)
    else $error("history state out of step with output beat");

  // First beat after reset has no history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !hist_q |=> vel_x_q == '0 && acc_y_q == '0)
    else $error("first beat after reset has nonzero velocity or acceleration");
`endif

endmodule
